// ----- src/light_gate_stopwatch_controller_macros.svh -----
// Assertion macros for the light-gate stopwatch controller.
// Used by the top level; relies on aclk and aresetn in the including scope.
`ifndef LIGHT_GATE_STOPWATCH_CONTROLLER_MACROS_SVH
`define LIGHT_GATE_STOPWATCH_CONTROLLER_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define LGSW_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Condition that must hold on every clock edge outside reset.
`define LGSW_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

`endif

// ----- src/lgsw_pkg.sv -----
// Shared types and constants for the light-gate stopwatch controller.
// No dependencies; imported by every module of the block.
package lgsw_pkg;

    typedef enum logic [2:0] {
        PH_CHECK1  = 3'd0,
        PH_CHECK2  = 3'd1,
        PH_ERROR   = 3'd2,
        PH_ARMED   = 3'd3,
        PH_HOLDOFF = 3'd4,
        PH_TIMING  = 3'd5,
        PH_STOPPED = 3'd6
    } phase_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_CHECK_WINDOW   = 2'd0;
    localparam logic [1:0] CFG_HOLDOFF_WINDOW = 2'd1;
    localparam logic [1:0] CFG_DISPLAY_PERIOD = 2'd2;

    localparam logic [7:0] CHECK_WINDOW_RST   = 8'd5;
    localparam logic [7:0] HOLDOFF_WINDOW_RST = 8'd2;
    localparam logic [9:0] DISPLAY_PERIOD_RST = 10'd99;

    localparam logic [9:0] MS_LAST   = 10'd999;
    localparam logic [5:0] SEC_LAST  = 6'd59;
    localparam logic [5:0] MIN_LAST  = 6'd59;
    localparam logic [6:0] HOUR_LAST = 7'd99;
    localparam logic [8:0] WIN_MAX   = 9'd511;

    typedef struct packed {
        logic [6:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic [9:0] millis;
        logic [8:0] window;
        logic [9:0] disp;
    } timer_t;

    typedef struct packed {
        logic ms_tick;
        logic gate_one_hit;
        logic gate_two_hit;
        logic button_down;
        logic restart_request;
    } event_t;

    typedef struct packed {
        logic [7:0] check_window_seconds;
        logic [7:0] holdoff_window_seconds;
        logic [9:0] display_period_ms;
    } cfg_t;

    typedef struct packed {
        phase_t phase;
        logic   led_on;
        logic   display_update;
        logic   time_captured;
    } ctrl_t;

    localparam timer_t TIMER_ZERO = '0;

    // The time counter runs only in these phases
    function automatic logic phase_runs(input phase_t ph);
        return (ph == PH_CHECK1) || (ph == PH_CHECK2) ||
               (ph == PH_HOLDOFF) || (ph == PH_TIMING);
    endfunction

endpackage

// ----- src/lgsw_tick.sv -----
// Millisecond advance of the h:m:s:ms counter, window and display sub-counter.
// Pure combinational; depends on lgsw_pkg.
module lgsw_tick import lgsw_pkg::*; (
    input  timer_t     cur,
    input  logic       tick_en,
    input  logic [9:0] display_period_ms,
    output timer_t     nxt,
    output logic       ticked
);

    logic saturated;

    assign saturated = (cur.hours >= HOUR_LAST) && (cur.minutes >= MIN_LAST) &&
                       (cur.seconds >= SEC_LAST) && (cur.millis >= MS_LAST);

    always_comb begin
        nxt    = cur;
        ticked = 1'b0;
        if (tick_en && !saturated) begin
            ticked = 1'b1;
            if (cur.millis >= MS_LAST) begin
                nxt.millis = '0;
                nxt.disp   = '0;
                if (cur.window < WIN_MAX) begin
                    nxt.window = cur.window + 9'd1;
                end
                if (cur.seconds >= SEC_LAST) begin
                    nxt.seconds = '0;
                    if (cur.minutes >= MIN_LAST) begin
                        nxt.minutes = '0;
                        nxt.hours   = cur.hours + 7'd1;
                    end else begin
                        nxt.minutes = cur.minutes + 6'd1;
                    end
                end else begin
                    nxt.seconds = cur.seconds + 6'd1;
                end
            end else begin
                nxt.millis = cur.millis + 10'd1;
                // wrap the display sub-counter once it reaches the period
                if (cur.disp >= display_period_ms) begin
                    nxt.disp = '0;
                end else begin
                    nxt.disp = cur.disp + 10'd1;
                end
            end
        end
    end

endmodule

// ----- src/lgsw_ctrl.sv -----
// Phase sequencer: sensor checks, arming, hold-off, timing and capture.
// Pure combinational next-state and output logic; depends on lgsw_pkg.
module lgsw_ctrl import lgsw_pkg::*; (
    input  phase_t phase,
    input  logic   led_on,
    input  event_t ev,
    input  cfg_t   cfg,
    input  timer_t timer_ticked,
    input  logic   ticked,
    output ctrl_t  ctrl,
    output timer_t timer_next
);

    phase_t phase_next;
    logic   check_expired;
    logic   holdoff_expired;
    logic   period_hit;

    assign check_expired   = timer_ticked.window > {1'b0, cfg.check_window_seconds};
    assign holdoff_expired = timer_ticked.window > {1'b0, cfg.holdoff_window_seconds};
    assign period_hit      = ticked && (timer_ticked.disp == cfg.display_period_ms);

    always_comb begin
        phase_next = phase;
        if (ev.restart_request) begin
            phase_next = PH_CHECK1;
        end else begin
            case (phase)
                PH_CHECK1: begin
                    if (ev.gate_one_hit) phase_next = PH_CHECK2;
                    else if (check_expired) phase_next = PH_ERROR;
                end
                PH_CHECK2: begin
                    if (ev.gate_two_hit) phase_next = PH_ARMED;
                    else if (check_expired) phase_next = PH_ERROR;
                end
                PH_ERROR: begin
                    if (ev.button_down) phase_next = PH_CHECK1;
                end
                PH_ARMED: begin
                    if (ev.gate_one_hit) phase_next = PH_HOLDOFF;
                end
                PH_HOLDOFF: begin
                    if (!ev.gate_one_hit && holdoff_expired) phase_next = PH_TIMING;
                end
                PH_TIMING: begin
                    if (ev.gate_two_hit) phase_next = PH_STOPPED;
                end
                PH_STOPPED: begin
                    if (ev.button_down) phase_next = PH_ARMED;
                end
                default: begin
                    phase_next = PH_CHECK1;
                end
            endcase
        end
    end

    always_comb begin
        ctrl.phase          = phase_next;
        ctrl.led_on         = led_on;
        ctrl.display_update = 1'b0;
        ctrl.time_captured  = 1'b0;
        timer_next          = timer_ticked;
        if (ev.restart_request) begin
            ctrl.led_on = 1'b0;
            timer_next  = TIMER_ZERO;
        end else begin
            case (phase)
                PH_CHECK1: begin
                    if (ev.gate_one_hit) timer_next = TIMER_ZERO;
                end
                PH_ERROR: begin
                    if (ev.button_down) timer_next = TIMER_ZERO;
                end
                PH_ARMED: begin
                    if (ev.gate_one_hit) begin
                        timer_next  = TIMER_ZERO;
                        ctrl.led_on = 1'b1;
                    end
                end
                PH_HOLDOFF: begin
                    // restart the hold-off window on every start-sensor hit
                    if (ev.gate_one_hit) timer_next.window = '0;
                end
                PH_TIMING: begin
                    if (ev.gate_two_hit) begin
                        ctrl.led_on        = 1'b0;
                        ctrl.time_captured = 1'b1;
                    end else if (period_hit) begin
                        ctrl.display_update = 1'b1;
                        ctrl.led_on         = !led_on;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ----- src/light_gate_stopwatch_controller.sv -----
// Light-gate stopwatch controller top level: input stage, state, result register.
// Depends on lgsw_pkg, lgsw_tick, lgsw_ctrl and the assertion macro header.
//
//  channel   direction  tdata fields (low bit up)
//  s_        in         ms_tick, gate_one_hit, gate_two_hit, button_down, restart_request
//  m_        out        phase, led_on, hours, minutes, seconds, millis,
//                       display_update, time_captured
//  cfg_      in         write enable, register index, write data
//
// Each beat is held in the input register, then the state update and result
// are formed in one pass of phase and counter logic and land in the result register.
// One beat per cycle is accepted when the result side keeps up.
// A stall on m_ holds the result register and then the input register; s_tready drops
// only when both are full. Reset (aresetn low, synchronous) clears state and loads the config defaults.
`include "light_gate_stopwatch_controller_macros.svh"

module light_gate_stopwatch_controller import lgsw_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // ms_tick, gate_one_hit, gate_two_hit, button_down, restart_request, zero pad
    input  logic [7:0]  s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // phase[2:0], led_on[3], hours[10:4], minutes[16:11], seconds[22:17],
    // millis[32:23], display_update[33], time_captured[34], zero pad
    output logic [39:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_wdata
);

    cfg_t   cfg_reg;
    logic   in_valid_reg;
    event_t in_reg;
    logic   out_valid_reg;
    ctrl_t  out_ctrl_reg;
    timer_t out_timer_reg;

    phase_t phase_reg;
    logic   led_reg;
    timer_t timer_reg;

    logic   advance;
    logic   tick_en;
    timer_t timer_ticked;
    logic   ticked;
    ctrl_t  ctrl_next;
    timer_t timer_next;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign tick_en  = in_reg.ms_tick && !in_reg.restart_request && phase_runs(phase_reg);

    lgsw_tick u_tick (
        .cur               (timer_reg),
        .tick_en           (tick_en),
        .display_period_ms (cfg_reg.display_period_ms),
        .nxt               (timer_ticked),
        .ticked            (ticked)
    );

    lgsw_ctrl u_ctrl (
        .phase        (phase_reg),
        .led_on       (led_reg),
        .ev           (in_reg),
        .cfg          (cfg_reg),
        .timer_ticked (timer_ticked),
        .ticked       (ticked),
        .ctrl         (ctrl_next),
        .timer_next   (timer_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.check_window_seconds   <= CHECK_WINDOW_RST;
            cfg_reg.holdoff_window_seconds <= HOLDOFF_WINDOW_RST;
            cfg_reg.display_period_ms      <= DISPLAY_PERIOD_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_CHECK_WINDOW:   cfg_reg.check_window_seconds   <= cfg_wdata[7:0];
                CFG_HOLDOFF_WINDOW: cfg_reg.holdoff_window_seconds <= cfg_wdata[7:0];
                CFG_DISPLAY_PERIOD: cfg_reg.display_period_ms      <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_CHECK1;
            led_reg       <= 1'b0;
            timer_reg     <= TIMER_ZERO;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                phase_reg     <= ctrl_next.phase;
                led_reg       <= ctrl_next.led_on;
                timer_reg     <= timer_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers: hold while stalled
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg.ms_tick         <= s_tdata[0];
            in_reg.gate_one_hit    <= s_tdata[1];
            in_reg.gate_two_hit    <= s_tdata[2];
            in_reg.button_down     <= s_tdata[3];
            in_reg.restart_request <= s_tdata[4];
        end
        if (advance) begin
            out_ctrl_reg  <= ctrl_next;
            out_timer_reg <= timer_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0,
                       out_ctrl_reg.time_captured,
                       out_ctrl_reg.display_update,
                       out_timer_reg.millis,
                       out_timer_reg.seconds,
                       out_timer_reg.minutes,
                       out_timer_reg.hours,
                       out_ctrl_reg.led_on,
                       3'(out_ctrl_reg.phase)};

    `LGSW_ASSERT_IMP(a_capture_stops, out_valid_reg && out_ctrl_reg.time_captured, out_ctrl_reg.phase == PH_STOPPED && !out_ctrl_reg.led_on, "capture beat not in stopped phase with LED off")
    `LGSW_ASSERT_IMP(a_update_timing, out_valid_reg && out_ctrl_reg.display_update, out_ctrl_reg.phase == PH_TIMING && !out_ctrl_reg.time_captured, "display update outside timing phase")
    `LGSW_ASSERT_IMP(a_result_matches_state, out_valid_reg, out_ctrl_reg.phase == phase_reg && out_ctrl_reg.led_on == led_reg && out_timer_reg == timer_reg, "result register out of step with state")
    `LGSW_ASSERT_ALWAYS(a_millis_range, timer_reg.millis <= MS_LAST && timer_reg.seconds <= SEC_LAST && timer_reg.minutes <= MIN_LAST, "time counter field out of range")

endmodule
